/* src/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define THP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define THP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/thp_pkg.sv */
// Types and constants of the three-axis homing sequencer.
package thp_pkg;

    // Sequence phase codes
    localparam logic [3:0] PH_IDLE          = 4'd0;
    localparam logic [3:0] PH_WAIT_LOCK     = 4'd1;
    localparam logic [3:0] PH_SETUP_FAST    = 4'd2;
    localparam logic [3:0] PH_FAST          = 4'd3;
    localparam logic [3:0] PH_SETUP_RETRACT = 4'd4;
    localparam logic [3:0] PH_RETRACT       = 4'd5;
    localparam logic [3:0] PH_SETUP_SLOW    = 4'd6;
    localparam logic [3:0] PH_SLOW          = 4'd7;
    localparam logic [3:0] PH_COMPLETED     = 4'd8;

    // Configuration register indexes
    localparam logic [2:0] CFG_HOME_END_MASK  = 3'd0;
    localparam logic [2:0] CFG_X_TRAVEL_STEPS = 3'd1;
    localparam logic [2:0] CFG_Y_TRAVEL_STEPS = 3'd2;
    localparam logic [2:0] CFG_Z_TRAVEL_STEPS = 3'd3;
    localparam logic [2:0] CFG_FAST_TICK_US   = 3'd4;
    localparam logic [2:0] CFG_SLOW_TICK_US   = 3'd5;

    localparam logic [19:0] FAST_PERIOD_RESET = 20'd100;
    localparam logic [19:0] SLOW_PERIOD_RESET = 20'd1000;

    typedef struct packed {
        logic [2:0]  home_end_mask;
        logic [30:0] x_travel_steps;
        logic [30:0] y_travel_steps;
        logic [30:0] z_travel_steps;
        logic [19:0] fast_tick_us;
        logic [19:0] slow_tick_us;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  phase;
        logic        retracting;
        logic        fast_selected;
        logic [2:0]  saved_source;
        logic [31:0] saved_id;
    } t_state;

    // Result word, first member in the top bits so step_mask lands in bit 0
    typedef struct packed {
        logic [31:0] reply_id;
        logic [2:0]  reply_source;
        logic [30:0] home_z_steps;
        logic [30:0] home_y_steps;
        logic [30:0] home_x_steps;
        logic        busy_res;
        logic        done_res;
        logic        lock_taken;
        logic        enable_motors;
        logic [19:0] update_period_us;
        logic [2:0]  direction_mask;
        logic [2:0]  step_mask;
    } t_result;

endpackage

/* src/three_axis_homing_sequencer.sv */
// Top level of the three-axis homing sequencer: ports, registers, output stage.
//
// Homing sequencer for three stepper axes. A word with tuser = 1 is a homing
// command and arms the sequence, saving its source and id; a word with
// tuser = 0 is one update tick and advances the sequence by at most one
// phase: wait for the stepper lock, fast setup (motor enable pulse), fast
// approach, retract setup, retract, slow setup, slow approach, completion.
// In the approaches every axis whose endstop is open steps toward its home
// end; in the retract every triggered axis steps away. A moving phase ends on
// the first tick without a step. Every input word yields exactly one output
// word, registered in the output stage when it is taken. The completion word carries done_res,
// the home position of each axis (0, or the travel register when homing to
// the maximum end) and the saved command source and id; in all other words
// those fields are zero. Throughput is one word per clock while the result side takes its words: the whole phase
// update is a single combinational pass between the state registers and the
// output register, and the output register lets a new word in while the
// last result is taken. Configuration writes are accepted every cycle and
// should only be issued while the sequencer is idle and no word is pending.
module three_axis_homing_sequencer import thp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,

    // Input words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [0] lock_free, [1] endstop_x, [2] endstop_y, [3] endstop_z,
    // [6:4] request_source, [38:7] command_id, [39] zero
    input  logic [39:0]  s_axis_tdata,
    // [0] cmd: 0 update tick, 1 homing command
    input  logic [0:0]   s_axis_tuser,

    // Result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] step_mask, [5:3] direction_mask, [25:6] update_period_us,
    // [26] enable_motors, [27] lock_taken, [28] done_res, [29] busy_res,
    // [60:30] home_x_steps, [91:61] home_y_steps, [122:92] home_z_steps,
    // [125:123] reply_source, [157:126] reply_id, [159:158] zero
    output logic [159:0] m_axis_tdata,

    // Configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_m_valid;
    logic    in_accept;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.home_end_mask  <= 3'd0;
            r_cfg.x_travel_steps <= 31'd0;
            r_cfg.y_travel_steps <= 31'd0;
            r_cfg.z_travel_steps <= 31'd0;
            r_cfg.fast_tick_us   <= FAST_PERIOD_RESET;
            r_cfg.slow_tick_us   <= SLOW_PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HOME_END_MASK:  r_cfg.home_end_mask  <= i_cfg_data[2:0];
                CFG_X_TRAVEL_STEPS: r_cfg.x_travel_steps <= i_cfg_data;
                CFG_Y_TRAVEL_STEPS: r_cfg.y_travel_steps <= i_cfg_data;
                CFG_Z_TRAVEL_STEPS: r_cfg.z_travel_steps <= i_cfg_data;
                CFG_FAST_TICK_US:   r_cfg.fast_tick_us   <= i_cfg_data[19:0];
                CFG_SLOW_TICK_US:   r_cfg.slow_tick_us   <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    // Take a new word whenever the output register is free or being drained
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    thp_phase_logic u_phase (
        .i_cmd            (s_axis_tuser[0]),
        .i_lock_free      (s_axis_tdata[0]),
        .i_endstops       (s_axis_tdata[3:1]),
        .i_request_source (s_axis_tdata[6:4]),
        .i_command_id     (s_axis_tdata[38:7]),
        .i_state          (r_state),
        .i_cfg            (r_cfg),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    // Sequencer state moves only on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (in_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_result};

endmodule

/* src/thp_phase_logic.sv */
// Next-phase and result logic for one tick or homing command.
module thp_phase_logic import thp_pkg::*; (
    input  logic        i_cmd,
    input  logic        i_lock_free,
    input  logic [2:0]  i_endstops,
    input  logic [2:0]  i_request_source,
    input  logic [31:0] i_command_id,
    input  t_state      i_state,
    input  t_cfg        i_cfg,
    output t_state      o_state,
    output t_result     o_result
);

    logic [2:0] steps;
    logic       enable;
    logic       locked;
    logic       done;

    always_comb begin
        o_state = i_state;
        steps   = 3'b000;
        enable  = 1'b0;
        locked  = 1'b0;
        done    = 1'b0;

        if (i_cmd) begin
            // new command overrides anything pending
            o_state.saved_source = i_request_source;
            o_state.saved_id     = i_command_id;
            o_state.phase        = PH_WAIT_LOCK;
        end else begin
            case (i_state.phase)
                PH_IDLE: begin
                end
                PH_WAIT_LOCK: begin
                    if (i_lock_free) begin
                        locked        = 1'b1;
                        o_state.phase = PH_SETUP_FAST;
                    end
                end
                PH_SETUP_FAST: begin
                    enable                = 1'b1;
                    o_state.retracting    = 1'b0;
                    o_state.fast_selected = 1'b1;
                    o_state.phase         = PH_FAST;
                end
                PH_FAST: begin
                    steps = ~i_endstops;
                    if (steps == 3'b000) o_state.phase = PH_SETUP_RETRACT;
                end
                PH_SETUP_RETRACT: begin
                    o_state.retracting = 1'b1;
                    o_state.phase      = PH_RETRACT;
                end
                PH_RETRACT: begin
                    steps = i_endstops;
                    if (steps == 3'b000) o_state.phase = PH_SETUP_SLOW;
                end
                PH_SETUP_SLOW: begin
                    o_state.retracting    = 1'b0;
                    o_state.fast_selected = 1'b0;
                    o_state.phase         = PH_SLOW;
                end
                PH_SLOW: begin
                    steps = ~i_endstops;
                    if (steps == 3'b000) o_state.phase = PH_COMPLETED;
                end
                PH_COMPLETED: begin
                    done          = 1'b1;
                    o_state.phase = PH_IDLE;
                end
                default: begin
                    o_state.phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_result.step_mask        = steps;
        o_result.direction_mask   = i_cfg.home_end_mask ^ {3{o_state.retracting}};
        o_result.update_period_us = o_state.fast_selected ? i_cfg.fast_tick_us
                                                          : i_cfg.slow_tick_us;
        o_result.enable_motors    = enable;
        o_result.lock_taken       = locked;
        o_result.done_res         = done;
        o_result.busy_res         = (o_state.phase != PH_IDLE);
        o_result.home_x_steps     = (done && i_cfg.home_end_mask[0]) ? i_cfg.x_travel_steps
                                                                     : 31'd0;
        o_result.home_y_steps     = (done && i_cfg.home_end_mask[1]) ? i_cfg.y_travel_steps
                                                                     : 31'd0;
        o_result.home_z_steps     = (done && i_cfg.home_end_mask[2]) ? i_cfg.z_travel_steps
                                                                     : 31'd0;
        o_result.reply_source     = done ? i_state.saved_source : 3'd0;
        o_result.reply_id         = done ? i_state.saved_id : 32'd0;
    end

endmodule

/* src/thp_checker.sv */
// Port-level checker for the homing sequencer and its bind.
`include "assert_macros.svh"

module thp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata
);

    // A stalled result word keeps its payload
    `THP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    // An empty output stage never back-pressures the input
    `THP_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output stage")

    // Positions and reply fields only appear in the completion word
    `THP_ASSERT_NOW(a_reply_only_done, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[28], m_axis_tdata[157:30] == 128'd0, "reply fields set without done")

    // Completion ends the sequence and moves no axis
    `THP_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[28], !m_axis_tdata[29] && m_axis_tdata[2:0] == 3'd0, "done word busy or stepping")

    // At most one of motor enable, lock taken and done per word
    `THP_ASSERT_NOW(a_one_pulse, i_clk, i_rst_n, m_axis_tvalid, $countones(m_axis_tdata[28:26]) <= 1, "more than one pulse in a word")

endmodule

bind three_axis_homing_sequencer thp_checker u_thp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/three_axis_homing_sequencer_tb.sv */
// Self-checking testbench for the three-axis homing sequencer: stream traffic and predictor.
module three_axis_homing_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import thp_pkg::*;

    // Mirror of the sequencer: register copy, phase state and the queue of
    // result words still owed by the block. Every input word owes exactly one.
    class homing_tracker;
        logic [2:0]  end_mask;
        logic [30:0] travel_x;
        logic [30:0] travel_y;
        logic [30:0] travel_z;
        logic [19:0] fast_us;
        logic [19:0] slow_us;
        logic [3:0]  phase;
        logic        retracting;
        logic        fast_sel;
        logic [2:0]  saved_src;
        logic [31:0] saved_id;
        t_result     awaited[$];
        int          errors;

        function new();
            end_mask   = '0;
            travel_x   = '0;
            travel_y   = '0;
            travel_z   = '0;
            fast_us    = FAST_PERIOD_RESET;
            slow_us    = SLOW_PERIOD_RESET;
            phase      = PH_IDLE;
            retracting = 1'b0;
            fast_sel   = 1'b0;
            saved_src  = '0;
            saved_id   = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [30:0] val);
            case (idx)
                CFG_HOME_END_MASK:  end_mask = val[2:0];
                CFG_X_TRAVEL_STEPS: travel_x = val;
                CFG_Y_TRAVEL_STEPS: travel_y = val;
                CFG_Z_TRAVEL_STEPS: travel_z = val;
                CFG_FAST_TICK_US:   fast_us  = val[19:0];
                CFG_SLOW_TICK_US:   slow_us  = val[19:0];
                default: ;
            endcase
        endfunction

        // Advance the mirror by one accepted input word and queue its result.
        function void accept_word(bit cmd, bit lock_free, logic [2:0] ends,
                                  logic [2:0] src, logic [31:0] id);
            t_result r;
            r = '0;
            if (cmd) begin
                // override: only identity and phase change, lock not tracked
                saved_src = src;
                saved_id  = id;
                phase     = PH_WAIT_LOCK;
            end else begin
                case (phase)
                    PH_WAIT_LOCK: begin
                        if (lock_free) begin
                            r.lock_taken = 1'b1;
                            phase        = PH_SETUP_FAST;
                        end
                    end
                    PH_SETUP_FAST: begin
                        r.enable_motors = 1'b1;
                        retracting      = 1'b0;
                        fast_sel        = 1'b1;
                        phase           = PH_FAST;
                    end
                    PH_FAST: begin
                        r.step_mask = ~ends;
                        if (r.step_mask == 3'b000) phase = PH_SETUP_RETRACT;
                    end
                    PH_SETUP_RETRACT: begin
                        retracting = 1'b1;
                        phase      = PH_RETRACT;
                    end
                    PH_RETRACT: begin
                        r.step_mask = ends;
                        if (r.step_mask == 3'b000) phase = PH_SETUP_SLOW;
                    end
                    PH_SETUP_SLOW: begin
                        retracting = 1'b0;
                        fast_sel   = 1'b0;
                        phase      = PH_SLOW;
                    end
                    PH_SLOW: begin
                        r.step_mask = ~ends;
                        if (r.step_mask == 3'b000) phase = PH_COMPLETED;
                    end
                    PH_COMPLETED: begin
                        r.done_res     = 1'b1;
                        r.home_x_steps = end_mask[0] ? travel_x : '0;
                        r.home_y_steps = end_mask[1] ? travel_y : '0;
                        r.home_z_steps = end_mask[2] ? travel_z : '0;
                        r.reply_source = saved_src;
                        r.reply_id     = saved_id;
                        phase          = PH_IDLE;
                    end
                    default: phase = PH_IDLE;
                endcase
            end
            r.direction_mask   = end_mask ^ {3{retracting}};
            r.update_period_us = fast_sel ? fast_us : slow_us;
            r.busy_res         = (phase != PH_IDLE);
            awaited.push_back(r);
        endfunction

        function void field_ok(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void check_reply(logic [159:0] word);
            t_result exp;
            t_result got;
            got = word[157:0];
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %h", $time, word);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            field_ok("step_mask", 32'(exp.step_mask), 32'(got.step_mask));
            field_ok("direction_mask", 32'(exp.direction_mask), 32'(got.direction_mask));
            field_ok("update_period_us", 32'(exp.update_period_us),
                     32'(got.update_period_us));
            field_ok("enable_motors", 32'(exp.enable_motors), 32'(got.enable_motors));
            field_ok("lock_taken", 32'(exp.lock_taken), 32'(got.lock_taken));
            field_ok("done_res", 32'(exp.done_res), 32'(got.done_res));
            field_ok("busy_res", 32'(exp.busy_res), 32'(got.busy_res));
            field_ok("home_x_steps", 32'(exp.home_x_steps), 32'(got.home_x_steps));
            field_ok("home_y_steps", 32'(exp.home_y_steps), 32'(got.home_y_steps));
            field_ok("home_z_steps", 32'(exp.home_z_steps), 32'(got.home_z_steps));
            field_ok("reply_source", 32'(exp.reply_source), 32'(got.reply_source));
            field_ok("reply_id", exp.reply_id, got.reply_id);
            field_ok("tdata pad", 32'd0, 32'(word[159:158]));
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [0] lock_free, [1] endstop_x, [2] endstop_y, [3] endstop_z,
    // [6:4] request_source, [38:7] command_id, [39] zero
    logic [39:0]  s_axis_tdata;
    // [0] cmd
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [2:0] step_mask .. [157:126] reply_id, [159:158] zero
    logic [159:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [30:0]  i_cfg_data;

    homing_tracker tracker = new();
    bit            steady;      // both sides stop idling while set
    int            sent;        // input words accepted so far

    three_axis_homing_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: back-pressure changes on the falling edge, roughly one
    // stalled cycle in ten outside the steady stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
    end

    // Every accepted result word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_reply(m_axis_tdata);
        end
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Send one word; called and returning on a falling edge. Random gaps drop
    // tvalid first, so valid is never lowered and raised in one step.
    task automatic send_word(bit cmd, bit lock_free, logic [2:0] ends,
                             logic [2:0] src, logic [31:0] id);
        while (!steady && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, id, src, ends, lock_free};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.accept_word(cmd, lock_free, ends, src, id);
        sent++;
        @(negedge i_clk);
    endtask

    // Hold the input side until every owed result word is back, then let the
    // output stage settle.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [30:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic program_regs(logic [2:0] mask, logic [30:0] tx, logic [30:0] ty,
                                logic [30:0] tz, logic [19:0] fast, logic [19:0] slow);
        cfg_write(CFG_HOME_END_MASK, {28'd0, mask});
        cfg_write(CFG_X_TRAVEL_STEPS, tx);
        cfg_write(CFG_Y_TRAVEL_STEPS, ty);
        cfg_write(CFG_Z_TRAVEL_STEPS, tz);
        cfg_write(CFG_FAST_TICK_US, {11'd0, fast});
        cfg_write(CFG_SLOW_TICK_US, {11'd0, slow});
        i_cfg_valid <= 1'b0;
    endtask

    // Tick a pending sequence through to completion with settled switches.
    task automatic finish_sequence();
        while (tracker.phase != PH_IDLE) begin
            send_word(1'b0, 1'b1,
                      (tracker.phase == PH_FAST || tracker.phase == PH_SLOW) ? 3'b111 : 3'b000,
                      3'($urandom), $urandom);
        end
    endtask

    // One homing run with plausible switch behavior: switches close one by
    // one in the approaches and open during the retract. A little noise on
    // the switches, rare overriding commands and rare full drains mixed in.
    task automatic homing_run();
        logic [2:0] ends;
        send_word(1'b1, 1'($urandom), 3'($urandom), 3'($urandom), $urandom);
        ends = 3'($urandom);
        while (tracker.phase != PH_IDLE) begin
            case (tracker.phase)
                PH_SETUP_FAST, PH_SETUP_SLOW: ends = 3'($urandom);
                PH_FAST, PH_SLOW:             ends |= 3'($urandom) & 3'($urandom);
                PH_RETRACT:                   ends &= 3'($urandom) | 3'($urandom);
                default: ;
            endcase
            if ($urandom_range(0, 99) < 3) ends = 3'($urandom);
            if ($urandom_range(0, 199) == 0) begin
                send_word(1'b1, 1'($urandom), ends, 3'($urandom), $urandom);
            end else begin
                send_word(1'b0,
                          (tracker.phase == PH_WAIT_LOCK) ? ($urandom_range(0, 2) == 0)
                                                          : 1'($urandom),
                          ends, 3'($urandom), $urandom);
            end
            if ($urandom_range(0, 149) == 0) quiesce();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        steady        = 1'b0;
        sent          = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pass on the reset register values.
        // Tick while idle: lock and switches must be ignored.
        send_word(1'b0, 1'b1, 3'b111, 3'd7, 32'hFFFF_FFFF);
        // Command with every side field high; no tick work in the same word.
        send_word(1'b1, 1'b1, 3'b111, 3'd7, 32'hFFFF_FFFF);
        send_word(1'b0, 1'b0, 3'b000, 3'd0, 32'd0);            // lock busy
        send_word(1'b1, 1'b0, 3'b000, 3'd0, 32'd0);            // override while waiting
        send_word(1'b0, 1'b1, 3'b000, 3'd0, 32'd0);            // lock taken
        send_word(1'b0, 1'b0, 3'b111, 3'd0, 32'd0);            // fast setup, switches ignored
        send_word(1'b0, 1'b0, 3'b000, 3'd0, 32'd0);            // all axes step
        send_word(1'b0, 1'b0, 3'b111, 3'd0, 32'd0);            // all closed, approach ends
        send_word(1'b0, 1'b0, 3'b000, 3'd0, 32'd0);            // retract setup
        send_word(1'b0, 1'b0, 3'b111, 3'd0, 32'd0);            // all back off
        send_word(1'b0, 1'b0, 3'b000, 3'd0, 32'd0);            // retract ends
        send_word(1'b0, 1'b1, 3'b010, 3'd0, 32'd0);            // slow setup
        send_word(1'b0, 1'b0, 3'b101, 3'd0, 32'd0);            // y alone steps
        send_word(1'b0, 1'b0, 3'b111, 3'd0, 32'd0);            // slow ends
        send_word(1'b0, 1'b1, 3'b111, 3'd0, 32'd0);            // completion word
        // Override in the middle of the fast approach: period and directions stay.
        send_word(1'b1, 1'b0, 3'b000, 3'd5, 32'hA5A5_5A5A);
        send_word(1'b0, 1'b1, 3'b000, 3'd0, 32'd0);
        send_word(1'b0, 1'b0, 3'b000, 3'd0, 32'd0);
        send_word(1'b0, 1'b0, 3'b010, 3'd0, 32'd0);
        send_word(1'b1, 1'b1, 3'b010, 3'd2, 32'h5A5A_A5A5);
        send_word(1'b0, 1'b0, 3'b000, 3'd0, 32'd0);            // lock not free yet
        finish_sequence();
        quiesce();

        // Random part in five register settings; extremes first.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: program_regs(3'b111, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                20'hFFFFF, 20'd0);
                1: program_regs(3'b000, 31'd0, 31'd0, 31'd0, 20'd0, 20'hFFFFF);
                default: program_regs(3'($urandom), 31'($urandom), 31'($urandom),
                                      31'($urandom), 20'($urandom), 20'($urandom));
            endcase
            steady = (p == 2);
            while (sent < 25 + (p + 1) * 265) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_word(1'b0, 1'($urandom), 3'($urandom), 3'($urandom), $urandom);
                end else begin
                    homing_run();
                end
            end
            quiesce();
        end
        steady = 1'b0;

        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
